// ----- rtl/core/sqa_pkg.sv -----
// ----------------------------------------------------------------------------
// sqa_pkg
// Shared types and constants of the sprite quadrant allocator.
// ----------------------------------------------------------------------------
package sqa_pkg;

  localparam int unsigned BANK_MAX = 8;
  localparam int unsigned BANK_W   = 3;
  localparam int unsigned SHAPE_W  = 4;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned WORD_W   = 8;

  localparam logic [SHAPE_W-1:0] SHAPE_FULL = 4'd15;
  localparam logic [SHAPE_W-1:0] SHAPE_WIDE = 4'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_TALL = 4'd5;
  localparam logic [SHAPE_W-1:0] SHAPE_ONE  = 4'd1;

  localparam logic [WORD_W-1:0] MASK_EAST  = 8'b0000_1010;
  localparam logic [WORD_W-1:0] MASK_SOUTH = 8'b0000_1100;
  localparam logic [WORD_W-1:0] HEAD_NW    = 8'h10;
  localparam logic [WORD_W-1:0] HEAD_NE    = 8'h20;
  localparam logic [WORD_W-1:0] HEAD_SW    = 8'h40;
  localparam logic [WORD_W-1:0] HEAD_SE    = 8'h80;
  localparam logic [WORD_W-1:0] QUAD_SE    = 8'h08;

  // Anchor offset, bit 0 is x and bit 1 is y.
  localparam logic [1:0] OFF_NONE = 2'b00;
  localparam logic [1:0] OFF_X    = 2'b01;
  localparam logic [1:0] OFF_Y    = 2'b10;
  localparam logic [1:0] OFF_XY   = 2'b11;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              fit;
    logic [1:0]        off;
    logic [WORD_W-1:0] word;
  } sqa_upd_t;

endpackage

// ----- rtl/core/sqa_if.sv -----
// ----------------------------------------------------------------------------
// sqa_req_if / sqa_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface sqa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [sqa_pkg::SHAPE_W-1:0]  shape_mask;
  logic [sqa_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, mode, shape_mask, slot, input ready);
  modport sink   (input valid, mode, shape_mask, slot, output ready);
endinterface

interface sqa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sqa_pkg::SLOT_W-1:0]  result_slot;
  logic                        failed;

  modport source (output valid, result_slot, failed, input ready);
  modport sink   (input valid, result_slot, failed, output ready);
endinterface

// ----- rtl/core/sqa_update.sv -----
// ----------------------------------------------------------------------------
// sqa_update
// Placement test and free rule applied to one bank occupancy word.
// ----------------------------------------------------------------------------
module sqa_update (
  input  logic                        mode_i,
  input  logic [sqa_pkg::SHAPE_W-1:0] shape_i,
  input  logic [1:0]                  off_i,
  input  logic [sqa_pkg::WORD_W-1:0]  word_i,
  output sqa_pkg::sqa_upd_t           upd_o
);
  import sqa_pkg::*;

  logic [WORD_W-1:0] m0, m1, m2;
  logic [3:0]        clr;
  logic [3:0]        inv;

  // The shifted shapes are tested unmasked, so they may hit head bits.
  assign m0 = {4'b0, shape_i};
  assign m1 = m0 << 1;
  assign m2 = m0 << 2;
  assign inv = ~word_i[7:4];

  always_comb begin
    clr = 4'b0;
    case (off_i)
      OFF_NONE: begin
        clr = inv | 4'b0001;
        if ((clr & 4'b0110) != 4'b0110) begin
          clr = clr & 4'b0111;
        end
      end
      OFF_X:   clr = (inv & 4'b1010) | 4'b0010;
      OFF_Y:   clr = (inv & 4'b1100) | 4'b0100;
      default: clr = 4'b1000;
    endcase
  end

  always_comb begin
    upd_o = '0;
    if (mode_i == MODE_FREE) begin
      upd_o.fit  = 1'b1;
      upd_o.off  = off_i;
      upd_o.word = word_i & ~{clr, clr};
    end else if ((word_i & m0) == '0) begin
      upd_o.fit  = 1'b1;
      upd_o.off  = OFF_NONE;
      upd_o.word = word_i | m0 | HEAD_NW;
    end else if (shape_i != SHAPE_FULL) begin
      if (shape_i != SHAPE_WIDE && (word_i & m1) == '0) begin
        upd_o.fit  = 1'b1;
        upd_o.off  = OFF_X;
        upd_o.word = word_i | (m1 & MASK_EAST) | HEAD_NE;
      end else if (shape_i != SHAPE_TALL && (word_i & m2) == '0) begin
        upd_o.fit  = 1'b1;
        upd_o.off  = OFF_Y;
        upd_o.word = word_i | (m2 & MASK_SOUTH) | HEAD_SW;
      end else if (shape_i == SHAPE_ONE && !word_i[3]) begin
        upd_o.fit  = 1'b1;
        upd_o.off  = OFF_XY;
        upd_o.word = word_i | QUAD_SE | HEAD_SE;
      end
    end
  end

endmodule

// ----- rtl/core/sprite_quadrant_allocator.sv -----
// ----------------------------------------------------------------------------
// sprite_quadrant_allocator
// Allocates and frees sprite quadrants in a small bank occupancy memory.
// ----------------------------------------------------------------------------
// Operation: a free reads only the addressed bank; an allocation scans from bank 0
// upward and answers at the first bank that fits, or fails after the last bank.
// One request at a time: the next is taken only once the response is registered;
// the scan reads one bank word per cycle through the single memory read port.
// Reset: all occupancy words read as zero at once (per-entry valid bits).
module sprite_quadrant_allocator #(
  parameter int unsigned BANK_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sqa_req_if.sink    req_i,
  sqa_rsp_if.source  rsp_o
);
  import sqa_pkg::*;

  localparam logic [BANK_W-1:0] LastBank = BANK_W'(BANK_COUNT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic                state_q, state_d;
  logic [BANK_W-1:0]   bank_q, bank_d;
  logic                mode_q;
  logic [SHAPE_W-1:0]  shape_q;
  logic [1:0]          off_q;

  logic [WORD_W-1:0]   mem [BANK_MAX];
  logic [BANK_MAX-1:0] valid_q;
  logic [WORD_W-1:0]   rd_q;
  logic                rd_valid_q;
  logic [BANK_W-1:0]   rd_addr;
  logic                rd_en;

  logic [WORD_W-1:0]   word;
  sqa_upd_t            upd;
  logic                out_free, finish, done, req_hs;

  logic                out_valid_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_failed_q;

  assign req_hs   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign word     = rd_valid_q ? rd_q : '0;

  sqa_update u_update (
    .mode_i  (mode_q),
    .shape_i (shape_q),
    .off_i   (off_q),
    .word_i  (word),
    .upd_o   (upd)
  );

  assign finish = (mode_q == MODE_FREE) || upd.fit || (bank_q == LastBank);
  assign done   = (state_q == ST_EVAL) && finish && out_free;

  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    rd_en   = 1'b0;
    rd_addr = bank_q + BANK_W'(1);
    if (state_q == ST_IDLE) begin
      rd_addr = (req_i.mode == MODE_FREE) ? req_i.slot[BANK_W-1:0] : '0;
      if (req_hs) begin
        rd_en   = 1'b1;
        state_d = ST_EVAL;
        bank_d  = rd_addr;
      end
    end else if (!finish) begin
      // No fit in this bank: fetch the next one.
      rd_en  = 1'b1;
      bank_d = bank_q + BANK_W'(1);
    end else if (done) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (done && upd.fit) begin
      mem[bank_q] <= upd.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
      if (done && upd.fit) begin
        valid_q[bank_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_hs) begin
      mode_q  <= req_i.mode;
      shape_q <= req_i.shape_mask;
      off_q   <= {req_i.slot[4], req_i.slot[3]};
    end
    if (done) begin
      out_slot_q   <= upd.fit ? {upd.off, bank_q} : '0;
      out_failed_q <= !upd.fit;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_slot = out_slot_q;
  assign rsp_o.failed      = out_failed_q;

  // A response only appears as the result of an evaluation step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EVAL))
    else $error("response raised without an evaluation");

  // A failed allocation always reports slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.failed) |-> (rsp_o.result_slot == '0))
    else $error("failed response carries a slot");

  // While the finished result waits on a full output, the scan holds its bank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && finish && !out_free) |=>
      ($stable(bank_q) && state_q == ST_EVAL))
    else $error("evaluation advanced under output backpressure");

endmodule
